>>> hdl/smt_pkg.sv
// Shared types and constants for the sine-taper multitaper spectrum core.
// Used by smt_divsqrt and sine_multitaper_spectrum_core; depends on nothing.
package smt_pkg;

    localparam int DATA_W    = 24;
    localparam int MUL_W     = 25;
    localparam int PROD_W    = 50;
    localparam int RES_W     = 32;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int L_W       = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPERS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMALISE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTING  = 3'd4;

    // Taper weighting codes.
    localparam logic [1:0] WEIGHT_UNIFORM   = 2'd0;
    localparam logic [1:0] WEIGHT_LINEAR    = 2'd1;
    localparam logic [1:0] WEIGHT_PARABOLIC = 2'd2;

    // Request type codes.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_RD1, S_RD2, S_DIF, S_M1, S_M2, S_M3,
        S_M4, S_M5, S_M6, S_DIV, S_WAIT, S_DONE
    } smt_state_t;

    typedef enum logic [2:0] {
        DS_IDLE, DS_DIV, DS_FIN, DS_SQRT, DS_DONE
    } smt_ds_state_t;

    typedef struct packed {
        logic start;
        logic amp;
    } smt_ds_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } smt_ds_rsp_t;

endpackage

>>> hdl/smt_divsqrt.sv
// Bit-serial saturating divider followed, when req.amp is set, by a bit-serial integer square root.
// Depends on smt_pkg.
module smt_divsqrt #(
    parameter int NUM_W = 67,
    parameter int DVS_W = 37
) (
    input  logic                clk,
    input  logic                rst_n,
    input  smt_pkg::smt_ds_req_t req,
    input  logic [NUM_W-1:0]    num,
    input  logic [DVS_W-1:0]    dvs,
    output smt_pkg::smt_ds_rsp_t rsp,
    output logic [31:0]         result
);
    import smt_pkg::*;

    localparam int QW = ((NUM_W > 64) ? NUM_W : 64) + 1;
    localparam int CW = $clog2(QW + 1);

    smt_ds_state_t     state_reg, state_next;
    logic [QW-1:0]     num_reg;
    logic [QW-1:0]     quot_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_reg;
    logic [CW-1:0]     cnt_reg;
    logic              amp_reg;
    logic [31:0]       root_reg;
    logic [33:0]       srem_reg;
    logic [63:0]       sq_reg;
    logic [31:0]       res_reg;

    logic [DVS_W:0]    rem_sh;
    logic              div_ge;
    logic [63:0]       q64;
    logic [35:0]       srem_sh;
    logic [35:0]       trial;
    logic              sq_ge;

    // One restoring division step.
    assign rem_sh = {rem_reg[DVS_W-1:0], num_reg[QW-1]};
    assign div_ge = (rem_sh >= {1'b0, dvs_reg});

    // Quotient saturated to 64 bits.
    assign q64 = (|quot_reg[QW-1:64]) ? {64{1'b1}} : quot_reg[63:0];

    // One square root digit step.
    assign srem_sh = {srem_reg, sq_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sq_ge   = (srem_sh >= trial);

    assign rsp.busy = (state_reg != DS_IDLE);
    assign rsp.done = (state_reg == DS_DONE);
    assign result   = res_reg;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DS_IDLE: if (req.start) state_next = DS_DIV;
            DS_DIV:  if (cnt_reg == CW'(1)) state_next = DS_FIN;
            DS_FIN:  state_next = amp_reg ? DS_SQRT : DS_DONE;
            DS_SQRT: if (cnt_reg == CW'(1)) state_next = DS_DONE;
            DS_DONE: state_next = DS_IDLE;
            default: state_next = DS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DS_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            DS_IDLE:
            begin
                num_reg  <= QW'(num);
                dvs_reg  <= dvs;
                amp_reg  <= req.amp;
                rem_reg  <= '0;
                quot_reg <= '0;
                cnt_reg  <= CW'(QW);
            end
            DS_DIV:
            begin
                rem_reg  <= div_ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                quot_reg <= {quot_reg[QW-2:0], div_ge};
                num_reg  <= {num_reg[QW-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CW'(1);
            end
            DS_FIN:
            begin
                sq_reg   <= q64;
                root_reg <= '0;
                srem_reg <= '0;
                cnt_reg  <= CW'(32);
                res_reg  <= (|q64[63:56]) ? 32'hFFFF_FFFF : q64[55:24];
            end
            DS_SQRT:
            begin
                srem_reg <= sq_ge ? 34'(srem_sh - trial) : srem_sh[33:0];
                root_reg <= {root_reg[30:0], sq_ge};
                sq_reg   <= {sq_reg[61:0], 2'b00};
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    res_reg <= {root_reg[30:0], sq_ge};
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

endmodule

>>> hdl/sine_multitaper_spectrum_core.sv
// Top level of the sine-taper multitaper spectrum core: bin store, taper sequencer
// and shared multiplier. Depends on smt_pkg and smt_divsqrt.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per request. A load
//   beat (req_type 0) writes one half-spectrum bin; a query beat
//   (req_type 1) asks for one output bin. Each query gives one beat on the output
//   channel (out_valid/out_ready): result_value and index_error. Loads give none.
//   A query runs on one shared 25x25 multiplier under a sequencer: a pass per
//   taper, then a bit-serial division and, in amplitude mode, a bit-serial square
//   root. A query with an index error skips the taper work and goes straight to
//   S_DONE. in_ready is low while a query is in work. The output register holds
//   a finished beat while the receiver stalls; new requests are taken meanwhile,
//   and a later query waits at its end until the held beat is taken. Reset
//   restores register defaults and empties the pipeline; the bin store is not
//   cleared and must be loaded first. Configuration writes take effect at once;
//   the user must make them only while idle, as the block does not enforce it.
module sine_multitaper_spectrum_core #(
    parameter int MAX_SIZE   = 1024,
    parameter int MAX_TAPERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [smt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smt_pkg::CFG_W-1:0]     cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [10:0] load_index,
    input  logic signed [23:0] bin_re,
    input  logic signed [23:0] bin_im,
    input  logic [9:0]  query_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic        index_error
);
    import smt_pkg::*;

    localparam int LOG2_MAX = $clog2(MAX_SIZE + 1) - 1;
    localparam int AW       = LOG2_MAX + 1;
    localparam int TW       = $clog2(MAX_TAPERS + 1);
    localparam int WW       = $clog2(MAX_TAPERS * MAX_TAPERS + 1);
    localparam int DW       = $clog2(MAX_TAPERS * MAX_TAPERS * MAX_TAPERS + 1);
    localparam int ACC_W    = PROD_W + WW + TW;
    localparam int NUM_W    = ACC_W + 3;
    localparam int DVS_W    = DW + 2 * LOG2_MAX;

    // Configuration registers.
    logic [L_W-1:0] size_log2_reg;
    logic [4:0]     num_tapers_reg;
    logic           normalise_reg;
    logic           amplitude_reg;
    logic [1:0]     weighting_reg;

    // Bin store.
    logic signed [DATA_W-1:0] re_mem [0:MAX_SIZE];
    logic signed [DATA_W-1:0] im_mem [0:MAX_SIZE];
    logic signed [DATA_W-1:0] rd_re_reg, rd_im_reg;
    logic                     conj_reg;

    smt_state_t      state_reg, state_next;
    logic [L_W-1:0]  l_reg;
    logic [9:0]      j_reg;
    logic [TW-1:0]   t_reg, k_reg;
    logic [1:0]      mode_reg;
    logic            norm_reg, amp_reg, err_reg;
    logic [WW-1:0]   tt_reg, sqk_reg, w_reg;
    logic [DW-1:0]   den_reg;
    logic [ACC_W-1:0] acc_reg;
    logic signed [MUL_W-1:0] r1_reg, i1_reg;
    logic [MUL_W-1:0] adr_reg, adi_reg;
    logic [PROD_W-1:0] p_reg, mul_reg;
    logic            out_valid_reg, out_valid_next;
    logic [RES_W-1:0] result_reg;
    logic            error_reg;

    logic            in_acc, load_acc, query_acc, out_free, post;
    logic [31:0]     l32, n32, t32;
    logic            query_err;
    logic [1:0]      mode_eff;
    logic [31:0]     n_cur, n2_cur, base, pos_raw, pos, rd_addr32;
    logic            mirror;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic [31:0]     load32;
    logic [MUL_W-1:0] mul_a, mul_b;
    logic signed [MUL_W-1:0] i2_ext;
    logic signed [25:0] dr, di;
    logic [31:0]     w32;
    smt_ds_req_t     ds_req;
    smt_ds_rsp_t     ds_rsp;
    logic [31:0]     ds_result;
    logic [NUM_W-1:0] ds_num;
    logic [DVS_W-1:0] ds_dvs;

    assign in_acc    = in_valid && in_ready;
    assign load_acc  = in_acc && (req_type == REQ_LOAD);
    assign query_acc = in_acc && (req_type == REQ_QUERY);
    assign out_free  = !out_valid_reg || out_ready;

    // Effective settings for a new query.
    assign l32 = (32'(size_log2_reg) > LOG2_MAX) ? 32'(LOG2_MAX) : 32'(size_log2_reg);
    assign n32 = 32'd1 << l32;
    assign query_err = (32'(query_index) > (n32 >> 1));
    assign t32 = (num_tapers_reg == 5'd0) ? 32'd1 :
                 ((32'(num_tapers_reg) > MAX_TAPERS) ? 32'(MAX_TAPERS)
                                                     : 32'(num_tapers_reg));
    assign mode_eff = (weighting_reg == WEIGHT_LINEAR)    ? WEIGHT_LINEAR :
                      (weighting_reg == WEIGHT_PARABOLIC) ? WEIGHT_PARABOLIC
                                                          : WEIGHT_UNIFORM;

    // Read position: wrap modulo 2N, mirror above N.
    assign n_cur     = 32'd1 << l_reg;
    assign n2_cur    = n_cur << 1;
    assign base      = 32'(j_reg) << 1;
    assign pos_raw   = (state_reg == S_RD1) ? (base + 32'(k_reg)) : (base - 32'(k_reg));
    assign pos       = pos_raw & (n2_cur - 32'd1);
    assign mirror    = (pos > n_cur);
    assign rd_addr32 = mirror ? (n2_cur - pos) : pos;
    assign rd_addr   = rd_addr32[AW-1:0];
    assign load32    = 32'(load_index);
    assign wr_addr   = load32[AW-1:0];

    // Second bin and per-taper differences.
    assign i2_ext = conj_reg ? -{rd_im_reg[DATA_W-1], rd_im_reg}
                             :  {rd_im_reg[DATA_W-1], rd_im_reg};
    assign dr = 26'(i2_ext) - 26'(i1_reg);
    assign di = 26'(r1_reg) - 26'(rd_re_reg);

    // Taper weight for the current k.
    always_comb
    begin
        case (mode_reg)
            WEIGHT_LINEAR:    w32 = 32'(t_reg) + 32'd1 - 32'(k_reg);
            WEIGHT_PARABOLIC: w32 = 32'(tt_reg) - 32'(sqk_reg);
            default:          w32 = 32'd1;
        endcase
    end

    // Shared multiplier operand select.
    always_comb
    begin
        case (state_reg)
            S_SQ:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(t_reg);
            end
            S_M1:
            begin
                mul_a = adr_reg;
                mul_b = adr_reg;
            end
            S_M2:
            begin
                mul_a = adi_reg;
                mul_b = adi_reg;
            end
            S_M4:
            begin
                mul_a = MUL_W'(w_reg);
                mul_b = p_reg[MUL_W-1:0];
            end
            S_M5:
            begin
                mul_a = MUL_W'(w_reg);
                mul_b = p_reg[PROD_W-1:MUL_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer next state and handshake outputs.
    always_comb
    begin
        state_next     = state_reg;
        post           = 1'b0;
        ds_req.start   = 1'b0;
        ds_req.amp     = amp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (query_acc)
                    state_next = query_err ? S_DONE : S_SQ;
            end
            S_SQ:  state_next = S_RD1;
            S_RD1: state_next = S_RD2;
            S_RD2: state_next = S_DIF;
            S_DIF: state_next = S_M1;
            S_M1:  state_next = S_M2;
            S_M2:  state_next = S_M3;
            S_M3:  state_next = S_M4;
            S_M4:  state_next = S_M5;
            S_M5:  state_next = S_M6;
            S_M6:  state_next = (k_reg == t_reg) ? S_DIV : S_RD1;
            S_DIV:
            begin
                ds_req.start = 1'b1;
                state_next   = S_WAIT;
            end
            S_WAIT:
            begin
                if (ds_rsp.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    post           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign index_error  = error_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            size_log2_reg  <= 4'd10;
            num_tapers_reg <= 5'd3;
            normalise_reg  <= 1'b1;
            amplitude_reg  <= 1'b1;
            weighting_reg  <= WEIGHT_PARABOLIC;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SIZE_LOG2:  size_log2_reg  <= cfg_data[L_W-1:0];
                    CFG_NUM_TAPERS: num_tapers_reg <= cfg_data;
                    CFG_NORMALISE:  normalise_reg  <= cfg_data[0];
                    CFG_AMPLITUDE:  amplitude_reg  <= cfg_data[0];
                    CFG_WEIGHTING:  weighting_reg  <= cfg_data[1:0];
                    default:        size_log2_reg  <= size_log2_reg;
                endcase
            end
        end
    end

    // Bin store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (load_acc && (load32 <= MAX_SIZE))
        begin
            re_mem[wr_addr] <= bin_re;
            im_mem[wr_addr] <= bin_im;
        end
        rd_re_reg <= re_mem[rd_addr];
        rd_im_reg <= im_mem[rd_addr];
        conj_reg  <= mirror;
    end

    // Taper datapath.
    always_ff @(posedge clk)
    begin
        mul_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        case (state_reg)
            S_IDLE:
            begin
                l_reg    <= l32[L_W-1:0];
                j_reg    <= query_index;
                t_reg    <= t32[TW-1:0];
                mode_reg <= mode_eff;
                norm_reg <= normalise_reg;
                amp_reg  <= amplitude_reg;
                err_reg  <= query_err;
                k_reg    <= TW'(1);
                acc_reg  <= '0;
                den_reg  <= '0;
                sqk_reg  <= '0;
            end
            S_RD1:
            begin
                if (k_reg == TW'(1))
                    tt_reg <= mul_reg[WW-1:0];
            end
            S_RD2:
            begin
                r1_reg <= {rd_re_reg[DATA_W-1], rd_re_reg};
                i1_reg <= conj_reg ? -{rd_im_reg[DATA_W-1], rd_im_reg}
                                   :  {rd_im_reg[DATA_W-1], rd_im_reg};
            end
            S_DIF:
            begin
                adr_reg <= dr[25] ? MUL_W'(-dr) : MUL_W'(dr);
                adi_reg <= di[25] ? MUL_W'(-di) : MUL_W'(di);
                w_reg   <= w32[WW-1:0];
            end
            S_M2: p_reg <= mul_reg;
            S_M3: p_reg <= p_reg + mul_reg;
            S_M5: acc_reg <= acc_reg + ACC_W'(mul_reg);
            S_M6:
            begin
                acc_reg <= acc_reg + (ACC_W'(mul_reg) << MUL_W);
                den_reg <= den_reg + DW'(w_reg);
                sqk_reg <= WW'(32'(sqk_reg) + (32'(k_reg) << 1) - 32'd1);
                k_reg   <= k_reg + TW'(1);
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (post)
        begin
            result_reg <= err_reg ? '0 : ds_result;
            error_reg  <= err_reg;
        end
    end

    // Divide by weight sum (and N squared), then optional square root.
    assign ds_num = {acc_reg, 3'b000};
    assign ds_dvs = DVS_W'(den_reg) << (norm_reg ? {l_reg, 1'b0} : 5'd0);

    smt_divsqrt #(
        .NUM_W (NUM_W),
        .DVS_W (DVS_W)
    ) u_divsqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ds_req),
        .num    (ds_num),
        .dvs    (ds_dvs),
        .rsp    (ds_rsp),
        .result (ds_result)
    );

endmodule

>>> hdl/smt_checker.sv
// Port-level checks for sine_multitaper_spectrum_core, attached by bind.
// Depends only on the top level's ports.
module smt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        req_type,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_value,
    input logic        index_error
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
                                    && $stable(index_error))
        else $error("output beat changed while stalled");

    // A flagged query always reports zero.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_error |-> result_value == 32'd0)
        else $error("index error with nonzero result");

    // Reset empties the output register.
    a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

    // A query occupies the block for at least the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type |=> !in_ready)
        else $error("ready right after a query");

    // A load never produces a result beat.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !req_type && !out_valid |=> !out_valid)
        else $error("result beat after a load");

endmodule

bind sine_multitaper_spectrum_core smt_checker u_smt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .index_error  (index_error)
);
